// ===== hdl/llif_pkg.sv =====
// Shared types and constants of the lamp line integrating filter.
`default_nettype none

package llif_pkg;

    // Word kinds on the input stream, carried in s_tuser.
    typedef enum logic [1:0] {
        MODE_PORT_E = 2'd0,
        MODE_PORT_I = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TRIGGER_HOLD = 3'd0,
        REG_ACC_CLAMP    = 3'd1,
        REG_HYST_THRESH  = 3'd2,
        REG_WEIGHT_CAP   = 3'd3,
        REG_STALE_LIMIT  = 3'd4
    } t_reg_idx;

    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned CLAMP_W  = 13;
    localparam int unsigned WEIGHT_W = 12;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned EVID_W   = 14;
    localparam int unsigned IDX_W    = 3;

    localparam logic [HOLD_W-1:0]   RST_TRIGGER_HOLD = 16'd1500;
    localparam logic [CLAMP_W-1:0]  RST_ACC_CLAMP    = 13'd4000;
    localparam logic [CLAMP_W-1:0]  RST_HYST_THRESH  = 13'd2000;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CAP   = 12'd1000;
    localparam logic [TIME_W-1:0]   RST_STALE_LIMIT  = 32'd1000000;

    // Port E bits that always follow the raw latch.
    localparam logic [3:0] PE_PASS_MASK = 4'hC;

    // Settings shared by both lamp lines for one tick.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [CLAMP_W-1:0]  clamp;
        logic [CLAMP_W-1:0]  thresh;
    } t_lane_cfg;

endpackage

`default_nettype wire

// ===== hdl/llif_lane.sv =====
// Evidence update, clamp and hysteresis decision for one lamp line.
`default_nettype none

module llif_lane (
    input  wire llif_pkg::t_lane_cfg                i_cfg,
    input  wire logic                               i_level,
    input  wire logic signed [llif_pkg::EVID_W-1:0] i_evidence,
    input  wire logic                               i_decision,
    output logic signed [llif_pkg::EVID_W-1:0]      o_evidence,
    output logic                                    o_decision
);
    import llif_pkg::*;

    // One extra bit of headroom covers the worst evidence plus weight.
    localparam int unsigned SUM_W = EVID_W + 1;

    logic signed [SUM_W-1:0] w_ev;
    logic signed [SUM_W-1:0] w_wt;
    logic signed [SUM_W-1:0] w_lim;
    logic signed [SUM_W-1:0] w_thr;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_clamped;

    assign w_ev  = SUM_W'(i_evidence);
    assign w_wt  = signed'(SUM_W'(i_cfg.weight));
    assign w_lim = signed'(SUM_W'(i_cfg.clamp));
    assign w_thr = signed'(SUM_W'(i_cfg.thresh));
    assign w_sum = i_level ? (w_ev + w_wt) : (w_ev - w_wt);

    always_comb begin
        w_clamped = w_sum;
        if (w_clamped > w_lim) begin
            w_clamped = w_lim;
        end
        if (w_clamped < -w_lim) begin
            w_clamped = -w_lim;
        end
    end

    assign o_evidence = w_clamped[EVID_W-1:0];

    // Clearing wins over setting when both thresholds are met.
    always_comb begin
        o_decision = i_decision;
        if (w_clamped >= w_thr) begin
            o_decision = 1'b1;
        end
        if (w_clamped <= -w_thr) begin
            o_decision = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lamp_line_integrating_filter.sv =====
// Top level of the lamp line integrating filter with its stream and register ports.
// An accepted word is held in the input register and its result word is loaded into
// the result register for the master side. Throughput: one word per cycle unless
// m_tready stalls the result register; the only loop is the state update.
// Reset (i_rst_n, synchronous, active low) clears all filter state, empties both
// pipeline registers and loads the configuration registers with their defaults.
`default_nettype none

module lamp_line_integrating_filter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [39:0]                     s_tdata,  // time_us[31:0], port_value[35:32]
    input  wire logic [1:0]                      s_tuser,  // mode[1:0]
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,  // pin_nibble[3:0], lamp_valid[4],
                                                           // lamp_bits[6:5], trigger_window[7]
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [llif_pkg::IDX_W-1:0]      i_cfg_idx,
    input  wire logic [llif_pkg::TIME_W-1:0]     i_cfg_data
);
    import llif_pkg::*;

    // Configuration registers.
    logic [HOLD_W-1:0]   r_trigger_hold;
    logic [CLAMP_W-1:0]  r_acc_clamp;
    logic [CLAMP_W-1:0]  r_hyst_thresh;
    logic [WEIGHT_W-1:0] r_weight_cap;
    logic [TIME_W-1:0]   r_stale_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_hold <= RST_TRIGGER_HOLD;
            r_acc_clamp    <= RST_ACC_CLAMP;
            r_hyst_thresh  <= RST_HYST_THRESH;
            r_weight_cap   <= RST_WEIGHT_CAP;
            r_stale_limit  <= RST_STALE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TRIGGER_HOLD: r_trigger_hold <= i_cfg_data[HOLD_W-1:0];
                REG_ACC_CLAMP:    r_acc_clamp    <= i_cfg_data[CLAMP_W-1:0];
                REG_HYST_THRESH:  r_hyst_thresh  <= i_cfg_data[CLAMP_W-1:0];
                REG_WEIGHT_CAP:   r_weight_cap   <= i_cfg_data[WEIGHT_W-1:0];
                REG_STALE_LIMIT:  r_stale_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register stage. A word moves on when the result register is free
    // or is being emptied in the same cycle.
    logic              r_in_valid;
    t_mode             r_in_mode;
    logic [TIME_W-1:0] r_in_time;
    logic [3:0]        r_in_value;
    logic              w_advance;

    logic              r_out_valid;
    logic [3:0]        r_out_pin;
    logic              r_out_lamp_valid;
    logic [1:0]        r_out_lamp_bits;
    logic              r_out_window;

    assign w_advance = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready  = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_mode  <= t_mode'(s_tuser);
            r_in_time  <= s_tdata[TIME_W-1:0];
            r_in_value <= s_tdata[TIME_W+3:TIME_W];
        end
    end

    // Filter state.
    logic [3:0]               r_raw_latch;
    logic [1:0]               r_decision;
    logic                     r_decision_valid;
    logic signed [EVID_W-1:0] r_evidence [2];
    logic [TIME_W-1:0]        r_last_tick;
    logic [TIME_W-1:0]        r_last_clean;
    logic                     r_access_seen;
    logic                     r_window_open;
    logic [TIME_W-1:0]        r_trigger_time;

    logic [3:0]               n_raw_latch;
    logic [1:0]               n_decision;
    logic                     n_decision_valid;
    logic signed [EVID_W-1:0] n_evidence [2];
    logic [TIME_W-1:0]        n_last_tick;
    logic [TIME_W-1:0]        n_last_clean;
    logic                     n_access_seen;
    logic                     n_window_open;
    logic [TIME_W-1:0]        n_trigger_time;
    logic [3:0]               n_pin;

    // Tick arithmetic: all differences are modulo 2^32 so timestamp wrap is harmless.
    logic [TIME_W-1:0]        w_gap;
    logic                     w_hold_done;
    logic                     w_stale_done;
    logic                     w_window_kept;
    logic                     w_clean;
    t_lane_cfg                w_lane_cfg;
    logic signed [EVID_W-1:0] w_lane_ev  [2];
    logic [1:0]               w_lane_dec;

    assign w_gap         = r_in_time - r_last_tick;
    assign w_hold_done   = (r_in_time - r_trigger_time) >= TIME_W'(r_trigger_hold);
    assign w_stale_done  = (r_in_time - r_last_clean) >= r_stale_limit;
    assign w_window_kept = r_window_open && !w_hold_done;
    assign w_clean       = !r_access_seen && !w_window_kept;

    // The evidence weight is the elapsed time, capped.
    assign w_lane_cfg.weight = (w_gap > TIME_W'(r_weight_cap)) ? r_weight_cap
                                                               : w_gap[WEIGHT_W-1:0];
    assign w_lane_cfg.clamp  = r_acc_clamp;
    assign w_lane_cfg.thresh = r_hyst_thresh;

    for (genvar g = 0; g < 2; g++) begin : g_lane
        llif_lane u_lane (
            .i_cfg      (w_lane_cfg),
            .i_level    (r_raw_latch[g]),
            .i_evidence (r_evidence[g]),
            .i_decision (r_decision[g]),
            .o_evidence (w_lane_ev[g]),
            .o_decision (w_lane_dec[g])
        );
    end

    always_comb begin
        n_raw_latch      = r_raw_latch;
        n_decision       = r_decision;
        n_decision_valid = r_decision_valid;
        n_evidence[0]    = r_evidence[0];
        n_evidence[1]    = r_evidence[1];
        n_last_tick      = r_last_tick;
        n_last_clean     = r_last_clean;
        n_access_seen    = r_access_seen;
        n_window_open    = r_window_open;
        n_trigger_time   = r_trigger_time;
        unique case (r_in_mode)
            MODE_PORT_E: begin
                n_raw_latch = r_in_value;
            end
            MODE_PORT_I: begin
                // Bit 1 flags a RAM access, bit 2 (re)opens the trigger window.
                if (r_in_value[1]) begin
                    n_access_seen = 1'b1;
                end
                if (r_in_value[2]) begin
                    n_trigger_time = r_in_time;
                    n_window_open  = 1'b1;
                end
            end
            MODE_TICK: begin
                n_last_tick   = r_in_time;
                n_window_open = w_window_kept;
                n_access_seen = 1'b0;
                if (w_clean) begin
                    n_last_clean     = r_in_time;
                    n_evidence[0]    = w_lane_ev[0];
                    n_evidence[1]    = w_lane_ev[1];
                    n_decision       = w_lane_dec;
                    n_decision_valid = 1'b1;
                end else if (r_decision_valid && w_stale_done) begin
                    // No clean interval for too long: fall back to raw.
                    n_decision_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Lamp bits replace the low pins only while a decision is in use and
    // no trigger window is open.
    assign n_pin = (!n_window_open && n_decision_valid)
                 ? ((n_raw_latch & PE_PASS_MASK) | {2'b00, n_decision})
                 : n_raw_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_latch      <= '0;
            r_decision       <= '0;
            r_decision_valid <= 1'b0;
            r_evidence[0]    <= '0;
            r_evidence[1]    <= '0;
            r_last_tick      <= '0;
            r_last_clean     <= '0;
            r_access_seen    <= 1'b0;
            r_window_open    <= 1'b0;
            r_trigger_time   <= '0;
        end else if (w_advance) begin
            r_raw_latch      <= n_raw_latch;
            r_decision       <= n_decision;
            r_decision_valid <= n_decision_valid;
            r_evidence[0]    <= n_evidence[0];
            r_evidence[1]    <= n_evidence[1];
            r_last_tick      <= n_last_tick;
            r_last_clean     <= n_last_clean;
            r_access_seen    <= n_access_seen;
            r_window_open    <= n_window_open;
            r_trigger_time   <= n_trigger_time;
        end
    end

    // Result register: loaded together with the state so it always shows
    // the state left behind by its own word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_pin        <= n_pin;
            r_out_lamp_valid <= n_decision_valid;
            r_out_lamp_bits  <= n_decision;
            r_out_window     <= n_window_open;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_window, r_out_lamp_bits, r_out_lamp_valid, r_out_pin};

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_time)
                                     && $stable(r_in_value))
        else $error("stalled input word changed");

    a_latch_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_mode == MODE_PORT_E |=> r_raw_latch == $past(r_in_value))
        else $error("port E write did not update raw latch");

    a_raw_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_window || !r_out_lamp_valid) |-> r_out_pin == r_raw_latch)
        else $error("pins not mirroring raw latch");

    a_lamp_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_window && r_out_lamp_valid
        |-> r_out_pin[1:0] == r_decision && r_out_pin[3:2] == r_raw_latch[3:2])
        else $error("pins disagree with lamp decision");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
